// ===== hdl/multi_motor_duty_soft_stop_unit_macros.svh =====
// Assertion macros for the motor duty soft-stop unit.
// Included by the top level; no other dependencies.
`ifndef MULTI_MOTOR_DUTY_SOFT_STOP_UNIT_MACROS_SVH
`define MULTI_MOTOR_DUTY_SOFT_STOP_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MMDSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMDSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mmdss_pkg.sv =====
// Shared types and constants for the motor duty soft-stop unit.
// No dependencies; imported by every module of the block.
package mmdss_pkg;

  localparam int MOTOR_COUNT_DEF = 4;
  localparam int DUTY_WIDTH_DEF  = 8;
  localparam int PCT_MAX         = 100;

  localparam int REQ_W       = 3;
  localparam int IDX_W       = 2;
  localparam int PCT_W       = 7;
  localparam int STEP_MS_W   = 16;
  localparam int STEP_DUTY_W = 8;
  localparam int OUT_DUTY_W  = 8;
  localparam int OUT_MOTORS  = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [STEP_MS_W-1:0]   STEP_MS_RESET   = 16'd50;
  localparam logic [STEP_DUTY_W-1:0] STEP_DUTY_RESET = 8'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET_POWER = 3'd0,
    REQ_DIR_HIGH  = 3'd1,
    REQ_DIR_LOW   = 3'd2,
    REQ_SOFT_STOP = 3'd3,
    REQ_TICK      = 3'd4
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_MS   = 1'b0,
    CFG_STEP_DUTY = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic set_power;
    logic dir_high;
    logic dir_low;
    logic soft_stop;
    logic tick;
  } chan_cmd_t;

endpackage

// ===== hdl/mmdss_channel.sv =====
// One motor channel: duty, direction and soft-stop ramp state.
// Depends on mmdss_pkg; instantiated by multi_motor_duty_soft_stop_unit.
module mmdss_channel
  import mmdss_pkg::*;
#(
  parameter int DUTY_WIDTH = DUTY_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  chan_cmd_t              cmd,
  input  logic [DUTY_WIDTH-1:0]  set_duty,
  input  logic [STEP_MS_W-1:0]   step_ms,
  input  logic [STEP_DUTY_W-1:0] step_duty,
  output logic [DUTY_WIDTH-1:0]  duty_new,
  output logic                   dir_new,
  output logic                   active_new,
  output logic                   done
);

  localparam int CmpW = (DUTY_WIDTH > STEP_DUTY_W) ? DUTY_WIDTH : STEP_DUTY_W;

  logic [DUTY_WIDTH-1:0] duty, duty_next;
  logic                  dir, dir_next;
  logic                  active, active_next;
  logic [STEP_MS_W-1:0]  tick_cnt, tick_cnt_next;
  logic [STEP_MS_W-1:0]  cnt_inc;
  logic                  step_hit;
  logic                  ramp_end;

  assign cnt_inc  = (tick_cnt != '1) ? tick_cnt + 1'b1 : tick_cnt;
  assign step_hit = (cnt_inc >= step_ms);
  assign ramp_end = (CmpW'(duty) <= CmpW'(step_duty));

  always_comb begin
    duty_next     = duty;
    dir_next      = dir;
    active_next   = active;
    tick_cnt_next = tick_cnt;
    done          = 1'b0;
    if (cmd.tick) begin
      if (active) begin
        tick_cnt_next = cnt_inc;
        if (step_hit) begin
          tick_cnt_next = '0;
          if (ramp_end) begin
            duty_next   = '0;
            active_next = 1'b0;
            done        = 1'b1;
          end else begin
            duty_next = duty - DUTY_WIDTH'(step_duty);
          end
        end
      end
    end else if (cmd.set_power) begin
      active_next = 1'b0;
      duty_next   = set_duty;
    end else if (cmd.dir_high) begin
      dir_next = 1'b1;
    end else if (cmd.dir_low) begin
      dir_next = 1'b0;
    end else if (cmd.soft_stop) begin
      if (duty != '0) begin
        active_next   = 1'b1;
        tick_cnt_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty     <= '0;
      dir      <= 1'b0;
      active   <= 1'b0;
      tick_cnt <= '0;
    end else if (en) begin
      duty     <= duty_next;
      dir      <= dir_next;
      active   <= active_next;
      tick_cnt <= tick_cnt_next;
    end
  end

  assign duty_new   = duty_next;
  assign dir_new    = dir_next;
  assign active_new = active_next;

endmodule

// ===== hdl/multi_motor_duty_soft_stop_unit.sv =====
// Four-channel motor duty controller with timed soft stop.
// Input beats carry a command or a millisecond tick (s_tuser = request kind,
// s_tdata = motor index and percent). Every input beat yields exactly one
// output beat on m_* showing all duties, direction, stopping and stop-done
// masks after that beat took effect.
// Config: cfg_wr_en/cfg_index/cfg_wdata write step_ms (index 0) and
// step_duty (index 1); write only while the block is idle.
// Path: input register, then result register, from input to output beat.
// Throughput: one beat per cycle while m_tready is high; the command decode,
// the percent-to-duty table and each channel's ramp step are one short pass.
// Reset (rst, synchronous): all duties zero, directions low, no ramp running,
// step_ms 50, step_duty 1, both stages empty.
// Stall: when m_tready is low the result register holds; one more beat waits
// in the input register, then s_tready drops until the result is taken.
// Depends on mmdss_pkg, mmdss_channel and the assertion macro header.
`include "multi_motor_duty_soft_stop_unit_macros.svh"

module multi_motor_duty_soft_stop_unit
  import mmdss_pkg::*;
#(
  parameter int MOTOR_COUNT = MOTOR_COUNT_DEF,
  parameter int DUTY_WIDTH  = DUTY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [1:0] motor_index, [8:2] percent
  input  logic [2:0]            s_tuser,   // [2:0] req_type
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [47:0]           m_tdata    // [7:0] duty_m0, [15:8] duty_m1,
                                           // [23:16] duty_m2, [31:24] duty_m3,
                                           // [35:32] direction_mask,
                                           // [39:36] stopping_mask,
                                           // [43:40] stop_done_mask
);

  localparam int DutyMax  = (1 << DUTY_WIDTH) - 1;
  localparam int PctDepth = 1 << PCT_W;

  logic [STEP_MS_W-1:0]   step_ms;
  logic [STEP_DUTY_W-1:0] step_duty;

  logic                   in_valid;
  logic [REQ_W-1:0]       in_req;
  logic [IDX_W-1:0]       in_idx;
  logic [PCT_W-1:0]       in_pct;
  logic                   adv;
  logic                   fire;

  logic [DUTY_WIDTH-1:0]  pct_lut [PctDepth];
  logic [DUTY_WIDTH-1:0]  set_duty;

  logic [DUTY_WIDTH-1:0]  ch_duty   [MOTOR_COUNT];
  logic [MOTOR_COUNT-1:0] ch_dir;
  logic [MOTOR_COUNT-1:0] ch_active;
  logic [MOTOR_COUNT-1:0] ch_done;

  logic [OUT_DUTY_W-1:0]  res_duty [OUT_MOTORS];
  logic [OUT_MOTORS-1:0]  res_dir, res_stop, res_done;
  logic [OUT_DUTY_W-1:0]  out_duty [OUT_MOTORS];
  logic [OUT_MOTORS-1:0]  out_dir, out_stop, out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ms   <= STEP_MS_RESET;
      step_duty <= STEP_DUTY_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STEP_MS:   step_ms   <= cfg_wdata[STEP_MS_W-1:0];
        CFG_STEP_DUTY: step_duty <= cfg_wdata[STEP_DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign fire     = in_valid && adv;
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req <= s_tuser[REQ_W-1:0];
      in_idx <= s_tdata[IDX_W-1:0];
      in_pct <= s_tdata[IDX_W+PCT_W-1:IDX_W];
    end
  end

  // Percent to duty, clamped above full scale.
  for (genvar g = 0; g < PctDepth; g++) begin : g_lut
    localparam int Pc = (g > PCT_MAX) ? PCT_MAX : g;
    assign pct_lut[g] = DUTY_WIDTH'((Pc * DutyMax) / PCT_MAX);
  end
  assign set_duty = pct_lut[in_pct];

  for (genvar i = 0; i < MOTOR_COUNT; i++) begin : g_chan
    chan_cmd_t cmd;
    logic      sel;
    assign sel = (32'(in_idx) == i);
    always_comb begin
      cmd = '0;
      unique case (in_req)
        REQ_SET_POWER: cmd.set_power = sel;
        REQ_DIR_HIGH:  cmd.dir_high  = sel;
        REQ_DIR_LOW:   cmd.dir_low   = sel;
        REQ_SOFT_STOP: cmd.soft_stop = sel;
        REQ_TICK:      cmd.tick      = 1'b1;
        default:       cmd           = '0;
      endcase
    end

    mmdss_channel #(
      .DUTY_WIDTH(DUTY_WIDTH)
    ) u_chan (
      .clk        (clk),
      .rst        (rst),
      .en         (fire),
      .cmd        (cmd),
      .set_duty   (set_duty),
      .step_ms    (step_ms),
      .step_duty  (step_duty),
      .duty_new   (ch_duty[i]),
      .dir_new    (ch_dir[i]),
      .active_new (ch_active[i]),
      .done       (ch_done[i])
    );
  end

  for (genvar o = 0; o < OUT_MOTORS; o++) begin : g_res
    if (o < MOTOR_COUNT) begin : g_on
      assign res_duty[o] = OUT_DUTY_W'(ch_duty[o]);
      assign res_dir[o]  = ch_dir[o];
      assign res_stop[o] = ch_active[o];
      assign res_done[o] = ch_done[o];
    end else begin : g_off
      assign res_duty[o] = '0;
      assign res_dir[o]  = 1'b0;
      assign res_stop[o] = 1'b0;
      assign res_done[o] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_duty <= res_duty;
      out_dir  <= res_dir;
      out_stop <= res_stop;
      out_done <= res_done;
    end
  end

  assign m_tdata = {4'b0, out_done, out_stop, out_dir,
                    out_duty[3], out_duty[2], out_duty[1], out_duty[0]};

  `MMDSS_ASSERT_NEXT(a_done_only_on_tick, clk, rst,
    fire && (in_req != REQ_TICK), out_done == '0, "stop done outside tick")
  `MMDSS_ASSERT_NOW(a_done_not_stopping, clk, rst,
    m_tvalid, (out_done & out_stop) == '0, "finished motor still stopping")
  `MMDSS_ASSERT_NOW(a_ready_only_on_stall, clk, rst,
    !s_tready, in_valid && m_tvalid && !m_tready, "input stalled without cause")

endmodule
